FILE: hdl/bcs_pkg.sv
// Shared types, widths and fixed-point helpers for the banded Cholesky solver.
`default_nettype none
package bcs_pkg;

   localparam int IDX_W = 6;
   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic signed [31:0] band_diag;
      logic signed [31:0] band_off_one;
      logic signed [31:0] band_off_two;
      logic signed [31:0] rhs_value;
      logic               last_frame;
   } req_type;

   typedef struct packed {
      logic signed [31:0] solution;
      logic [IDX_W-1:0]   frame_index;
      logic               pivot_error;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      req_type          frame;
      logic [IDX_W-1:0] index;
      logic             take;
   } cmd_type;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = -32'sh7fff_ffff - 32'sh1;

   function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] prod);
      logic signed [63:0] shifted;
      logic signed [31:0] res;
      shifted = prod >>> FRAC_BITS;
      if (shifted > 64'(Q_MAX)) res = Q_MAX;
      else if (shifted < 64'(Q_MIN)) res = Q_MIN;
      else res = shifted[31:0];
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/bcs_front.sv
// Front end: accepts frames, numbers them within the run and marks the ones to store.
`default_nettype none
module bcs_front #(
   parameter int MAX_FRAMES = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire bcs_pkg::req_type req_data,
   input  wire logic            q_full,
   output logic                 q_push,
   output bcs_pkg::cmd_type     q_data
);
   localparam int CW = $clog2(MAX_FRAMES + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          take;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;
   assign take     = cnt_ff < CW'(MAX_FRAMES);

   always_comb begin
      q_data.frame = req_data;
      q_data.index = bcs_pkg::IDX_W'(cnt_ff);
      q_data.take  = take;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (q_push) begin
         if (req_data.last_frame) cnt_in = '0;
         else if (take) cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/bcs_queue.sv
// Two-entry queue between the front end and the solve engine.
`default_nettype none
module bcs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bcs_pkg::cmd_type data_in,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output bcs_pkg::cmd_type      data_out
);
   bcs_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign data_out = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= data_in;
   end
endmodule
`default_nettype wire

FILE: hdl/bcs_sqrt.sv
// Bit-serial integer square root of a pivot scaled by 2^16, one root bit per cycle.
`default_nettype none
module bcs_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [30:0] value,
   output logic             done,
   output logic [23:0]      root
);
   logic [47:0] rad_ff;
   logic [24:0] rem_ff;
   logic [23:0] root_ff;
   logic [4:0]  step_ff;
   logic        busy_ff, done_ff;
   logic [26:0] rem_shift, trial;
   logic        ge;
   logic [24:0] rem_in;
   logic [23:0] root_in;

   assign rem_shift = {rem_ff, rad_ff[47:46]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign ge        = rem_shift >= trial;
   assign rem_in    = ge ? 25'(rem_shift - trial) : 25'(rem_shift);
   assign root_in   = {root_ff[22:0], ge};
   assign done      = done_ff;
   assign root      = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 5'd23;
         end else if (busy_ff) begin
            if (step_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {1'b0, value, 16'b0};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[45:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/bcs_div.sv
// Restoring Q16.16 divider, one quotient bit per cycle, saturating.
`default_nettype none
module bcs_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [33:0] num,
   input  wire logic [31:0]        den,
   output logic                    done,
   output logic signed [31:0]      quo
);
   logic [31:0] den_ff, rem_ff, dvd_ff, q_ff;
   logic        neg_ff, ovf_ff;
   logic [5:0]  step_ff;
   logic        busy_ff, done_ff;
   logic signed [31:0] quo_ff;
   logic [33:0] mag;
   logic [32:0] rem_shift;
   logic        ge;
   logic [31:0] rem_in;

   assign mag       = num[33] ? 34'(-num) : 34'(num);
   assign rem_shift = {rem_ff, dvd_ff[31]};
   assign ge        = rem_shift >= {1'b0, den_ff};
   assign rem_in    = ge ? 32'(rem_shift - {1'b0, den_ff}) : rem_shift[31:0];
   assign done      = done_ff;
   assign quo       = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 6'd32;
         end else if (busy_ff) begin
            if (step_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         neg_ff <= num[33];
         ovf_ff <= {14'b0, mag[33:16]} >= den;
         rem_ff <= {14'b0, mag[33:16]};
         dvd_ff <= {mag[15:0], 16'b0};
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (step_ff != 6'd0) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[30:0], 1'b0};
            q_ff   <= {q_ff[30:0], ge};
         end else if (!neg_ff) begin
            quo_ff <= (ovf_ff || q_ff[31]) ? bcs_pkg::Q_MAX : $signed(q_ff);
         end else begin
            quo_ff <= (ovf_ff || q_ff > 32'h8000_0000) ? bcs_pkg::Q_MIN : $signed(-q_ff);
         end
      end
   end
endmodule
`default_nettype wire

FILE: hdl/bcs_back.sv
// Solve engine: factor row, forward step, row store and backward pass.
`default_nettype none
module bcs_back #(
   parameter int MAX_FRAMES = 64,
   parameter int BAND_WIDTH = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   output logic                  q_pop,
   input  wire bcs_pkg::cmd_type q_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output bcs_pkg::rsp_type      rsp_data
);
   localparam int  AW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int  CW      = $clog2(MAX_FRAMES + 1);
   localparam logic USE_TWO = BAND_WIDTH >= 3;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CLASS = 5'd1;
   localparam logic [4:0] S_M1    = 5'd2;
   localparam logic [4:0] S_M2    = 5'd3;
   localparam logic [4:0] S_PIV   = 5'd4;
   localparam logic [4:0] S_SQRT  = 5'd5;
   localparam logic [4:0] S_M3    = 5'd6;
   localparam logic [4:0] S_D1    = 5'd7;
   localparam logic [4:0] S_W1    = 5'd8;
   localparam logic [4:0] S_W2    = 5'd9;
   localparam logic [4:0] S_M4    = 5'd10;
   localparam logic [4:0] S_M5    = 5'd11;
   localparam logic [4:0] S_D3    = 5'd12;
   localparam logic [4:0] S_W3    = 5'd13;
   localparam logic [4:0] S_WR    = 5'd14;
   localparam logic [4:0] S_BINIT = 5'd15;
   localparam logic [4:0] S_BRD   = 5'd16;
   localparam logic [4:0] S_BM1   = 5'd17;
   localparam logic [4:0] S_BM2   = 5'd18;
   localparam logic [4:0] S_BD    = 5'd19;
   localparam logic [4:0] S_BW    = 5'd20;
   localparam logic [4:0] S_BOUT  = 5'd21;
   localparam logic [4:0] S_EOUT  = 5'd22;

   typedef struct packed {
      logic signed [31:0] l0;
      logic signed [31:0] l1;
      logic signed [31:0] l2;
      logic signed [31:0] y;
   } row_type;

   logic [4:0]          state_ff, state_in;
   bcs_pkg::cmd_type    cmd_ff, cmd_in;
   logic                err_ff, err_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic signed [31:0]  l1p_ff, l1p_in, l2p_ff, l2p_in, yp_ff, yp_in;
   logic signed [31:0]  l2pp_ff, l2pp_in, ypp_ff, ypp_in;
   logic signed [31:0]  l0_ff, l0_in, l1_ff, l1_in, l2_ff, l2_in, y_ff, y_in;
   logic signed [31:0]  acc_ff, acc_in, x_ff, x_in;
   logic signed [31:0]  bw0_ff, bw0_in, bw1_ff, bw1_in;
   logic [AW-1:0]       bt_ff, bt_in;
   logic                out_valid_ff, out_valid_in;
   bcs_pkg::rsp_type    out_ff, out_in;
   logic signed [63:0]  prod_ff;
   logic signed [31:0]  mul_a, mul_b, prod_q;
   row_type             mem [MAX_FRAMES];
   row_type             rd_ff;
   logic                mem_we;
   logic                slot_free, t1, t2;
   logic signed [34:0]  piv;
   logic                sq_start, sq_done;
   logic [23:0]         sq_root;
   logic                div_start, div_done;
   logic signed [33:0]  div_num;
   logic [31:0]         div_den;
   logic signed [31:0]  div_quo;

   bcs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (piv[30:0]),
      .done  (sq_done),
      .root  (sq_root)
   );

   bcs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign slot_free = !out_valid_ff || rsp_pop;
   assign t1        = cmd_ff.index != '0;
   assign t2        = cmd_ff.index >= bcs_pkg::IDX_W'(2);
   assign prod_q    = bcs_pkg::qmul_sat(prod_ff);
   assign piv       = 35'(cmd_ff.frame.band_diag) - (35'(acc_ff) + 35'(prod_q));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      l1p_in       = l1p_ff;
      l2p_in       = l2p_ff;
      yp_in        = yp_ff;
      l2pp_in      = l2pp_ff;
      ypp_in       = ypp_ff;
      l0_in        = l0_ff;
      l1_in        = l1_ff;
      l2_in        = l2_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      bw0_in       = bw0_ff;
      bw1_in       = bw1_ff;
      bt_in        = bt_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = l0_ff;
      mem_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (err_ff) state_in = cmd_ff.frame.last_frame ? S_EOUT : S_IDLE;
            else if (!cmd_ff.take) state_in = cmd_ff.frame.last_frame ? S_BINIT : S_IDLE;
            else state_in = S_M1;
         end
         S_M1: begin
            mul_a    = t1 ? l1p_ff : '0;
            mul_b    = mul_a;
            state_in = S_M2;
         end
         S_M2: begin
            acc_in   = prod_q;
            mul_a    = (t2 && USE_TWO) ? l2pp_ff : '0;
            mul_b    = mul_a;
            state_in = S_PIV;
         end
         S_PIV: begin
            if (piv[34] || piv == '0) begin
               err_in   = 1'b1;
               state_in = cmd_ff.frame.last_frame ? S_EOUT : S_IDLE;
            end else begin
               sq_start = 1'b1;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sq_done) begin
               l0_in    = {8'b0, sq_root};
               state_in = S_M3;
            end
         end
         S_M3: begin
            mul_a    = (t1 && USE_TWO) ? l2p_ff : '0;
            mul_b    = l1p_ff;
            state_in = S_D1;
         end
         S_D1: begin
            div_start = 1'b1;
            div_num   = 34'(cmd_ff.frame.band_off_one) - 34'(prod_q);
            state_in  = S_W1;
         end
         S_W1: begin
            if (div_done) begin
               l1_in = div_quo;
               if (USE_TWO) begin
                  div_start = 1'b1;
                  div_num   = 34'(cmd_ff.frame.band_off_two);
                  state_in  = S_W2;
               end else begin
                  l2_in    = '0;
                  state_in = S_M4;
               end
            end
         end
         S_W2: begin
            if (div_done) begin
               l2_in    = div_quo;
               state_in = S_M4;
            end
         end
         S_M4: begin
            mul_a    = t1 ? l1p_ff : '0;
            mul_b    = yp_ff;
            state_in = S_M5;
         end
         S_M5: begin
            acc_in   = prod_q;
            mul_a    = (t2 && USE_TWO) ? l2pp_ff : '0;
            mul_b    = ypp_ff;
            state_in = S_D3;
         end
         S_D3: begin
            div_start = 1'b1;
            div_num   = 34'(cmd_ff.frame.rhs_value) - 34'(acc_ff) - 34'(prod_q);
            state_in  = S_W3;
         end
         S_W3: begin
            if (div_done) begin
               y_in     = div_quo;
               state_in = S_WR;
            end
         end
         S_WR: begin
            mem_we   = 1'b1;
            l2pp_in  = l2p_ff;
            ypp_in   = yp_ff;
            l1p_in   = l1_ff;
            l2p_in   = l2_ff;
            yp_in    = y_ff;
            cnt_in   = CW'(cmd_ff.index) + CW'(1);
            state_in = cmd_ff.frame.last_frame ? S_BINIT : S_IDLE;
         end
         S_BINIT: begin
            bw0_in   = '0;
            bw1_in   = '0;
            bt_in    = AW'(cnt_ff - CW'(1));
            state_in = S_BRD;
         end
         S_BRD: begin
            state_in = S_BM1;
         end
         S_BM1: begin
            mul_a    = rd_ff.l1;
            mul_b    = bw0_ff;
            state_in = S_BM2;
         end
         S_BM2: begin
            acc_in   = prod_q;
            mul_a    = USE_TWO ? rd_ff.l2 : '0;
            mul_b    = bw1_ff;
            state_in = S_BD;
         end
         S_BD: begin
            div_start = 1'b1;
            div_num   = 34'(rd_ff.y) - 34'(acc_ff) - 34'(prod_q);
            div_den   = rd_ff.l0;
            state_in  = S_BW;
         end
         S_BW: begin
            if (div_done) begin
               x_in     = div_quo;
               state_in = S_BOUT;
            end
         end
         S_BOUT: begin
            if (slot_free) begin
               out_valid_in       = 1'b1;
               out_in.solution    = x_ff;
               out_in.frame_index = bcs_pkg::IDX_W'(bt_ff);
               out_in.pivot_error = 1'b0;
               out_in.last_result = bt_ff == '0;
               bw1_in             = bw0_ff;
               bw0_in             = x_ff;
               if (bt_ff == '0) begin
                  cnt_in   = '0;
                  err_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  bt_in    = bt_ff - AW'(1);
                  state_in = S_BRD;
               end
            end
         end
         S_EOUT: begin
            if (slot_free) begin
               out_valid_in       = 1'b1;
               out_in.solution    = '0;
               out_in.frame_index = '0;
               out_in.pivot_error = 1'b1;
               out_in.last_result = 1'b1;
               cnt_in             = '0;
               err_in             = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         err_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      l1p_ff  <= l1p_in;
      l2p_ff  <= l2p_in;
      yp_ff   <= yp_in;
      l2pp_ff <= l2pp_in;
      ypp_ff  <= ypp_in;
      l0_ff   <= l0_in;
      l1_ff   <= l1_in;
      l2_ff   <= l2_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      bw0_ff  <= bw0_in;
      bw1_ff  <= bw1_in;
      bt_ff   <= bt_in;
      out_ff  <= out_in;
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[cmd_ff.index[AW-1:0]] <= '{l0: l0_ff, l1: l1_ff, l2: l2_ff, y: y_ff};
      rd_ff <= mem[bt_ff];
   end
endmodule
`default_nettype wire

FILE: hdl/banded_cholesky_solver.sv
// Top level of the banded Cholesky solver: front end, queue and solve engine.
//
// Frames enter on the req_ queue port (push/full) as one req_data item each:
// diagonal, first and second upper band entries, right-hand side, last flag.
// Results leave on the rsp_ queue port (empty/pop), oldest first.
// Each stored frame in the engine takes a square root, multiplies and three divisions
// (two if BAND_WIDTH is below 3) through one shared divider. A frame dropped after
// an error or past MAX_FRAMES is only classified and not stored.
// On the last frame the backward pass gives one result per stored frame,
// last stored frame first, each from two multiplies and one division.
// A failed pivot gives a single error result on the last frame instead.
// Up to two frames wait in the queue while the engine is busy.
// Reset clears the run and the queue; the row store needs no clearing.
// A stalled receiver holds the result register and stops the backward pass;
// frames keep queueing until the queue is full.
`default_nettype none
module banded_cholesky_solver #(
   parameter int MAX_FRAMES = 64,
   parameter int BAND_WIDTH = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire bcs_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output bcs_pkg::rsp_type      rsp_data
);
   logic             f_push, q_full, q_empty, q_pop;
   bcs_pkg::cmd_type f_data, q_data;

   bcs_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (f_push),
      .q_data   (f_data)
   );

   bcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .data_in  (f_data),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_data)
   );

   bcs_back #(.MAX_FRAMES(MAX_FRAMES), .BAND_WIDTH(BAND_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: hdl/bcs_checker.sv
// Port-level checks for the banded Cholesky solver and their binding.
`default_nettype none
module bcs_port_checks (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire bcs_pkg::rsp_type rsp_data
);
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.pivot_error) |->
         (rsp_data.last_result && rsp_data.frame_index == '0 && rsp_data.solution == '0))
      else $error("malformed error result");

   a_last_frame0: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.pivot_error) |->
         (rsp_data.last_result == (rsp_data.frame_index == '0)))
      else $error("last flag does not match frame zero");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_result) |=>
         (rsp_empty || rsp_data.pivot_error ||
          rsp_data.frame_index == $past(rsp_data.frame_index) - 6'd1))
      else $error("results out of order");
endmodule

bind banded_cholesky_solver bcs_port_checks u_bcs_port_checks (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
`default_nettype wire
